FILE: rtl/oct_enc_pkg.sv
package oct_enc_pkg;

  localparam int unsigned COMPONENT_WIDTH_DEF = 16;

  localparam int unsigned OCT_W = 16;

  // quotient is at most 32767, fits in 15 bits
  localparam int unsigned QUOT_BITS = 15;

  localparam logic [OCT_W-1:0] OCT_ZERO_CODE = 16'h8000;

  typedef struct packed {
    logic neg_u;
    logic neg_v;
    logic zero;
  } oct_flags_t;

endpackage

FILE: rtl/oct_in_if.sv
interface oct_in_if
  import oct_enc_pkg::*;
#(
  parameter int unsigned W = COMPONENT_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] normal_x;
  logic signed [W-1:0] normal_y;
  logic signed [W-1:0] normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

FILE: rtl/oct_out_if.sv
interface oct_out_if
  import oct_enc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OCT_W-1:0] oct_u;
  logic signed [OCT_W-1:0] oct_v;

  modport source (output valid, output oct_u, output oct_v, input ready);
  modport sink   (input valid, input oct_u, input oct_v, output ready);
endinterface

FILE: rtl/octahedral_normal_encode_core.sv
// pipeline: 3 setup stages, one stage per quotient bit (15 divider cells) and
// the output register
// throughput: one item per cycle, each divider cell resolves one bit for both lanes
// stalls only fill empty stages, ready ripples back through the stage valid bits
// reset: rst_ni asynchronous active low clears all stage valid bits, pipeline empty
module octahedral_normal_encode_core
  import oct_enc_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oct_in_if.sink     in_i,
  oct_out_if.source  out_o
);

  localparam int unsigned W     = COMPONENT_WIDTH;
  localparam int unsigned LEN_W = W + 1;
  localparam int unsigned DEN_W = W + 2;
  localparam int unsigned REM_W = LEN_W + OCT_W;

  logic                 valid [QUOT_BITS+1];
  logic                 ready [QUOT_BITS+1];
  logic [DEN_W-1:0]     den   [QUOT_BITS+1];
  logic [REM_W-1:0]     rem_u [QUOT_BITS+1];
  logic [REM_W-1:0]     rem_v [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_u [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_v [QUOT_BITS+1];
  oct_flags_t           flags [QUOT_BITS+1];

  logic                 out_valid_q;
  logic [OCT_W-1:0]     out_u_q, out_v_q;
  logic [OCT_W-1:0]     out_u_d, out_v_d;
  logic [OCT_W-1:0]     qu_ext, qv_ext;
  oct_flags_t           fl_last;

  oct_enc_prep #(
    .W (W)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .den_o   (den[0]),
    .num_u_o (rem_u[0]),
    .num_v_o (rem_v[0]),
    .flags_o (flags[0])
  );

  assign quo_u[0] = '0;
  assign quo_v[0] = '0;

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    oct_enc_cell #(
      .W     (W),
      .SHIFT (QUOT_BITS - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .den_i   (den[i]),
      .rem_u_i (rem_u[i]),
      .rem_v_i (rem_v[i]),
      .quo_u_i (quo_u[i]),
      .quo_v_i (quo_v[i]),
      .flags_i (flags[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .den_o   (den[i+1]),
      .rem_u_o (rem_u[i+1]),
      .rem_v_o (rem_v[i+1]),
      .quo_u_o (quo_u[i+1]),
      .quo_v_o (quo_v[i+1]),
      .flags_o (flags[i+1])
    );
  end

  // output register
  assign ready[QUOT_BITS] = !out_valid_q || out_o.ready;
  assign fl_last          = flags[QUOT_BITS];
  assign qu_ext           = OCT_W'(quo_u[QUOT_BITS]);
  assign qv_ext           = OCT_W'(quo_v[QUOT_BITS]);

  always_comb begin
    if (fl_last.zero) begin
      out_u_d = OCT_ZERO_CODE;
      out_v_d = OCT_ZERO_CODE;
    end else begin
      out_u_d = fl_last.neg_u ? ({OCT_W{1'b0}} - qu_ext) : qu_ext;
      out_v_d = fl_last.neg_v ? ({OCT_W{1'b0}} - qv_ext) : qv_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready[QUOT_BITS]) begin
      out_valid_q <= valid[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[QUOT_BITS] && valid[QUOT_BITS]) begin
      out_u_q <= out_u_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.oct_u = out_u_q;
  assign out_o.oct_v = out_v_q;

endmodule

FILE: rtl/oct_enc_prep.sv
module oct_enc_prep
  import oct_enc_pkg::*;
#(
  parameter int unsigned W = COMPONENT_WIDTH_DEF,
  localparam int unsigned LEN_W = W + 1,
  localparam int unsigned DEN_W = W + 2,
  localparam int unsigned REM_W = LEN_W + OCT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  oct_in_if.sink           in_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DEN_W-1:0] den_o,
  output logic [REM_W-1:0] num_u_o,
  output logic [REM_W-1:0] num_v_o,
  output oct_flags_t       flags_o
);

  // stage a: magnitudes and signs
  logic             va_q;
  logic             ra;
  logic [W-1:0]     ax_q, ay_q, az_q;
  logic [W-1:0]     ax_d, ay_d, az_d;
  logic             nx_q, ny_q, nz_q;

  // stage b: length and folded magnitudes
  logic             vb_q;
  logic             rb;
  logic [LEN_W-1:0] len_b_q, mu_q, mv_q;
  logic [LEN_W-1:0] len_b_d, mu_d, mv_d;
  logic             nu_b_q, nv_b_q, zero_b_q;

  // stage c: numerators and denominator
  logic             vc_q;
  logic             rc;
  logic [REM_W-1:0] mu_ext, mv_ext, len_ext;
  logic [REM_W-1:0] num_u_q, num_v_q;
  logic [DEN_W-1:0] den_q;
  oct_flags_t       flags_q;

  assign rc         = !vc_q || ready_i;
  assign rb         = !vb_q || rc;
  assign ra         = !va_q || rb;
  assign in_i.ready = ra;

  always_comb begin
    ax_d = in_i.normal_x[W-1] ? ({W{1'b0}} - W'(in_i.normal_x)) : W'(in_i.normal_x);
    ay_d = in_i.normal_y[W-1] ? ({W{1'b0}} - W'(in_i.normal_y)) : W'(in_i.normal_y);
    az_d = in_i.normal_z[W-1] ? ({W{1'b0}} - W'(in_i.normal_z)) : W'(in_i.normal_z);
  end

  always_comb begin
    len_b_d = LEN_W'(ax_q) + LEN_W'(ay_q) + LEN_W'(az_q);
    // folded: len - |y| = |x| + |z|, len - |x| = |y| + |z|
    mu_d    = nz_q ? (LEN_W'(ax_q) + LEN_W'(az_q)) : LEN_W'(ax_q);
    mv_d    = nz_q ? (LEN_W'(ay_q) + LEN_W'(az_q)) : LEN_W'(ay_q);
  end

  // 65534 * mag + len
  assign mu_ext  = REM_W'(mu_q);
  assign mv_ext  = REM_W'(mv_q);
  assign len_ext = REM_W'(len_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) va_q <= in_i.valid;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra && in_i.valid) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
      nx_q <= in_i.normal_x[W-1];
      ny_q <= in_i.normal_y[W-1];
      nz_q <= in_i.normal_z[W-1];
    end
    if (rb && va_q) begin
      len_b_q  <= len_b_d;
      mu_q     <= mu_d;
      mv_q     <= mv_d;
      nu_b_q   <= nx_q;
      nv_b_q   <= ny_q;
      zero_b_q <= (ax_q | ay_q | az_q) == '0;
    end
    if (rc && vb_q) begin
      num_u_q       <= (mu_ext << OCT_W) - (mu_ext << 1) + len_ext;
      num_v_q       <= (mv_ext << OCT_W) - (mv_ext << 1) + len_ext;
      den_q         <= {len_b_q, 1'b0};
      flags_q.neg_u <= nu_b_q;
      flags_q.neg_v <= nv_b_q;
      flags_q.zero  <= zero_b_q;
    end
  end

  assign valid_o = vc_q;
  assign den_o   = den_q;
  assign num_u_o = num_u_q;
  assign num_v_o = num_v_q;
  assign flags_o = flags_q;

endmodule

FILE: rtl/oct_enc_cell.sv
module oct_enc_cell
  import oct_enc_pkg::*;
#(
  parameter int unsigned W     = COMPONENT_WIDTH_DEF,
  parameter int unsigned SHIFT = 0,
  localparam int unsigned LEN_W = W + 1,
  localparam int unsigned DEN_W = W + 2,
  localparam int unsigned REM_W = LEN_W + OCT_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [DEN_W-1:0]     den_i,
  input  logic [REM_W-1:0]     rem_u_i,
  input  logic [REM_W-1:0]     rem_v_i,
  input  logic [QUOT_BITS-1:0] quo_u_i,
  input  logic [QUOT_BITS-1:0] quo_v_i,
  input  oct_flags_t           flags_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [DEN_W-1:0]     den_o,
  output logic [REM_W-1:0]     rem_u_o,
  output logic [REM_W-1:0]     rem_v_o,
  output logic [QUOT_BITS-1:0] quo_u_o,
  output logic [QUOT_BITS-1:0] quo_v_o,
  output oct_flags_t           flags_o
);

  logic                 valid_q;
  logic [DEN_W-1:0]     den_q;
  logic [REM_W-1:0]     rem_u_q, rem_v_q, rem_u_d, rem_v_d;
  logic [QUOT_BITS-1:0] quo_u_q, quo_v_q;
  oct_flags_t           flags_q;
  logic [REM_W-1:0]     den_sh;
  logic                 take_u, take_v;

  assign ready_o = !valid_q || ready_i;

  // one restoring quotient bit per lane
  assign den_sh  = REM_W'(den_i) << SHIFT;
  assign take_u  = rem_u_i >= den_sh;
  assign take_v  = rem_v_i >= den_sh;
  assign rem_u_d = take_u ? (rem_u_i - den_sh) : rem_u_i;
  assign rem_v_d = take_v ? (rem_v_i - den_sh) : rem_v_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      den_q   <= den_i;
      rem_u_q <= rem_u_d;
      rem_v_q <= rem_v_d;
      quo_u_q <= {quo_u_i[QUOT_BITS-2:0], take_u};
      quo_v_q <= {quo_v_i[QUOT_BITS-2:0], take_v};
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign rem_u_o = rem_u_q;
  assign rem_v_o = rem_v_q;
  assign quo_u_o = quo_u_q;
  assign quo_v_o = quo_v_q;
  assign flags_o = flags_q;

endmodule

FILE: test/testbench.sv
module testbench
  import oct_enc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW           = COMPONENT_WIDTH_DEF;
  localparam longint      SNORM_MAX    = 32767;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TABLE_ROWS   = 21;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic signed [OCT_W-1:0] u;
    logic signed [OCT_W-1:0] v;
  } oct_code_t;

  typedef struct packed {
    comp_t     x;
    comp_t     y;
    comp_t     z;
    logic      known;
    oct_code_t code;
  } normal_row_t;

  logic clk_i;
  logic rst_ni;

  oct_in_if #(.W(CW)) in_if ();
  oct_out_if          out_if ();

  octahedral_normal_encode_core #(
    .COMPONENT_WIDTH(CW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  oct_code_t   expected_codes[$];
  int unsigned mismatch_count = 0;
  bit          gaps_on        = 1'b1;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  // directed vectors; known rows carry the code, the rest go through the predictor
  normal_row_t normal_table [TABLE_ROWS] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{OCT_ZERO_CODE, OCT_ZERO_CODE}},
    '{16'sd1,      16'sd0,      16'sd0,      1'b1, '{16'sd32767, 16'sd0}},
    '{-16'sd1,     16'sd0,      16'sd0,      1'b1, '{-16'sd32767, 16'sd0}},
    '{16'sd0,      16'sd1,      16'sd0,      1'b1, '{16'sd0, 16'sd32767}},
    '{16'sd0,      -16'sd1,     16'sd0,      1'b1, '{16'sd0, -16'sd32767}},
    '{16'sd0,      16'sd0,      16'sd1,      1'b1, '{16'sd0, 16'sd0}},
    '{16'sd0,      16'sd0,      -16'sd1,     1'b1, '{16'sd32767, 16'sd32767}},
    '{16'sh8000,   16'sd0,      16'sd0,      1'b1, '{-16'sd32767, 16'sd0}},
    '{16'sd0,      16'sd0,      16'sh8000,   1'b1, '{16'sd32767, 16'sd32767}},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '{16'sd0, 16'sd0}},
    '{16'sh8000,   16'sh8000,   16'sh8000,   1'b0, '{16'sd0, 16'sd0}},
    '{16'sd32767,  16'sh8000,   16'sd0,      1'b0, '{16'sd0, 16'sd0}},
    '{16'sd1,      16'sd1,      16'sd0,      1'b0, '{16'sd0, 16'sd0}},
    '{-16'sd1,     -16'sd1,     16'sd0,      1'b0, '{16'sd0, 16'sd0}},
    '{16'sd1,      16'sd2,      16'sd0,      1'b0, '{16'sd0, 16'sd0}},
    '{-16'sd1,     16'sd0,      -16'sd1,     1'b0, '{16'sd0, 16'sd0}},
    '{16'sd0,      -16'sd1,     -16'sd1,     1'b0, '{16'sd0, 16'sd0}},
    '{16'sd1,      16'sd1,      -16'sd1,     1'b0, '{16'sd0, 16'sd0}},
    '{16'sh8000,   16'sd32767,  16'sh8000,   1'b0, '{16'sd0, 16'sd0}},
    '{16'sh5555,   16'shaaaa,   16'sh0f0f,   1'b0, '{16'sd0, 16'sd0}},
    '{16'sh7fff,   16'sh8000,   16'sh7fff,   1'b0, '{16'sd0, 16'sd0}}
  };

  // round(32767*mag/len), half away from zero, then signed
  function automatic logic [OCT_W-1:0] snorm_round(longint mag, bit neg, longint len);
    longint q;
    q = (2 * SNORM_MAX * mag + len) / (2 * len);
    if (neg) begin
      q = -q;
    end
    return q[OCT_W-1:0];
  endfunction

  function automatic oct_code_t encode_normal(comp_t x, comp_t y, comp_t z);
    longint    ax, ay, az, len, mu, mv;
    oct_code_t code;
    ax  = (x < 0) ? -longint'(x) : longint'(x);
    ay  = (y < 0) ? -longint'(y) : longint'(y);
    az  = (z < 0) ? -longint'(z) : longint'(z);
    len = ax + ay + az;
    if (len == 0) begin
      code.u = OCT_ZERO_CODE;
      code.v = OCT_ZERO_CODE;
      return code;
    end
    // lower hemisphere folds over the diagonals, zero counts as positive
    if (z < 0) begin
      mu = len - ay;
      mv = len - ax;
    end else begin
      mu = ax;
      mv = ay;
    end
    code.u = snorm_round(mu, x < 0, len);
    code.v = snorm_round(mv, y < 0, len);
    return code;
  endfunction

  function automatic comp_t random_component();
    comp_t c;
    case ($urandom_range(5))
      0: c = comp_t'(int'($urandom_range(8)) - 4);
      1: begin
        case ($urandom_range(3))
          0: c = 16'sh8000;
          1: c = 16'sh7fff;
          2: c = 16'sh8001;
          default: c = '0;
        endcase
      end
      2: c = comp_t'(int'($urandom_range(255)) - 128);
      default: c = comp_t'($urandom());
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string field, logic [OCT_W-1:0] got, logic [OCT_W-1:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", field, got, want, $realtime);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_normal(comp_t x, comp_t y, comp_t z, oct_code_t code);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.normal_x <= x;
    in_if.normal_y <= y;
    in_if.normal_z <= z;
    do @(posedge clk_i); while (!in_if.ready);
    expected_codes = {expected_codes, code};
    @(negedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (expected_codes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.normal_x = '0;
    in_if.normal_y = '0;
    in_if.normal_z = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: random back-pressure plus one long hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = LONG_HOLD - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    oct_code_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_codes.size() == 0) begin
        $display("unexpected result %h %h at %0t", out_if.oct_u, out_if.oct_v, $realtime);
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_if.oct_u !== want.u) begin
          report_mismatch("oct_u", out_if.oct_u, want.u);
        end
        if (out_if.oct_v !== want.v) begin
          report_mismatch("oct_v", out_if.oct_v, want.v);
        end
      end
    end
  end

  initial begin
    comp_t     x, y, z;
    oct_code_t code;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    foreach (normal_table[i]) begin
      code = normal_table[i].known ? normal_table[i].code :
             encode_normal(normal_table[i].x, normal_table[i].y, normal_table[i].z);
      send_normal(normal_table[i].x, normal_table[i].y, normal_table[i].z, code);
    end

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // steady stretch with no idling on either side
      gaps_on = !(i >= 400 && i < 650);
      if (i == 800) begin
        hold_req = 1'b1;
      end
      if (i == 1100) begin
        in_if.valid <= 1'b0;
        wait_results_drained();
        @(negedge clk_i);
      end
      x = random_component();
      y = random_component();
      z = random_component();
      send_normal(x, y, z, encode_normal(x, y, z));
    end
    in_if.valid <= 1'b0;

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("timeout at %0t", $realtime);
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: octahedral_normal_encode_core.f
rtl/oct_enc_pkg.sv
rtl/oct_in_if.sv
rtl/oct_out_if.sv
rtl/oct_enc_prep.sv
rtl/oct_enc_cell.sv
rtl/octahedral_normal_encode_core.sv
test/testbench.sv
